>>> hdl/dsi_pkg.sv
// Shared types and request codes for the distinct set intersection block.
package dsi_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_OUT_W = 7;

    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_LOAD  = 2'd1;
    localparam logic [1:0] REQ_PROBE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic compare;
        logic shift_sec;
        logic shift_emt;
    } t_cell_ctl;

endpackage

>>> hdl/dsi_cell.sv
// One cell of the store chain: a second-set entry, an emitted entry and their comparators.
module dsi_cell (
    input  logic                             i_clk,
    input  dsi_pkg::t_cell_ctl               i_ctl,
    input  logic [dsi_pkg::VALUE_W-1:0]      i_key,
    input  logic                             i_sec_vld,
    input  logic                             i_emt_vld,
    input  logic [dsi_pkg::VALUE_W-1:0]      i_sec_prev,
    input  logic [dsi_pkg::VALUE_W-1:0]      i_emt_prev,
    output logic [dsi_pkg::VALUE_W-1:0]      o_sec_val,
    output logic [dsi_pkg::VALUE_W-1:0]      o_emt_val,
    output logic                             o_sec_hit,
    output logic                             o_emt_hit
);

    logic [dsi_pkg::VALUE_W-1:0] r_sec_val;
    logic [dsi_pkg::VALUE_W-1:0] r_emt_val;
    logic                        r_sec_hit;
    logic                        r_emt_hit;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_sec) begin
            r_sec_val <= i_sec_prev;
        end
        if (i_ctl.shift_emt) begin
            r_emt_val <= i_emt_prev;
        end
        if (i_ctl.compare) begin
            r_sec_hit <= i_sec_vld && (r_sec_val == i_key);
            r_emt_hit <= i_emt_vld && (r_emt_val == i_key);
        end
    end

    assign o_sec_val = r_sec_val;
    assign o_emt_val = r_emt_val;
    assign o_sec_hit = r_sec_hit;
    assign o_emt_hit = r_emt_hit;

endmodule

>>> hdl/distinct_set_intersection_top.sv
// Top level of the order-preserving distinct set intersection block.
// A request is accepted in ST_IDLE, compared in every cell in ST_CMP the next cycle, and its
// result is registered in ST_DONE once the output register is free or being read.
// A new request is accepted only after the current one has committed its result in ST_DONE.
// Reset clears the control state, output valid and both entry counts; entry contents are left as is.
module distinct_set_intersection_top #(
    parameter int unsigned SET_DEPTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [1:0]                          i_req_type,
    input  logic signed [dsi_pkg::VALUE_W-1:0]  i_item_value,
    input  logic                                i_final_probe,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [dsi_pkg::VALUE_W-1:0]  o_out_value,
    output logic                                o_emitted,
    output logic                                o_in_second_set,
    output logic                                o_overflow,
    output logic [dsi_pkg::COUNT_OUT_W-1:0]     o_emitted_count,
    output logic                                o_set_done
);

    localparam int unsigned CW = $clog2(SET_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(SET_DEPTH);

    dsi_pkg::t_state r_state;
    dsi_pkg::t_state n_state;

    logic [1:0]                  r_req;
    logic [dsi_pkg::VALUE_W-1:0] r_key;
    logic                        r_fin;
    logic [CW-1:0]               r_sec_cnt;
    logic [CW-1:0]               n_sec_cnt;
    logic [CW-1:0]               r_emt_cnt;
    logic [CW-1:0]               n_emt_cnt;

    logic                        r_out_vld;
    logic [dsi_pkg::VALUE_W-1:0] r_out_value;
    logic                        r_out_emit;
    logic                        r_out_match;
    logic                        r_out_ovf;
    logic [CW-1:0]               r_out_cnt;
    logic                        r_out_done;

    logic [dsi_pkg::VALUE_W-1:0] n_out_value;
    logic                        n_out_emit;
    logic                        n_out_match;
    logic                        n_out_ovf;
    logic                        n_out_done;

    dsi_pkg::t_cell_ctl w_ctl;
    logic               w_compare;
    logic               w_shift_sec;
    logic               w_shift_emt;
    logic               w_commit;
    logic               w_sec_any;
    logic               w_emt_any;

    logic [dsi_pkg::VALUE_W-1:0] w_sec_chain [SET_DEPTH+1];
    logic [dsi_pkg::VALUE_W-1:0] w_emt_chain [SET_DEPTH+1];
    logic [SET_DEPTH-1:0]        w_sec_hit;
    logic [SET_DEPTH-1:0]        w_emt_hit;
    logic [CW+dsi_pkg::COUNT_OUT_W-1:0] w_cnt_ext;

    assign w_sec_chain[0] = r_key;
    assign w_emt_chain[0] = r_key;

    assign w_ctl = '{compare: w_compare, shift_sec: w_shift_sec, shift_emt: w_shift_emt};

    // newest entry enters cell 0; valid entries occupy cells below the count
    for (genvar g = 0; g < SET_DEPTH; g++) begin : g_cell
        dsi_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_key      (r_key),
            .i_sec_vld  (r_sec_cnt > CW'(g)),
            .i_emt_vld  (r_emt_cnt > CW'(g)),
            .i_sec_prev (w_sec_chain[g]),
            .i_emt_prev (w_emt_chain[g]),
            .o_sec_val  (w_sec_chain[g+1]),
            .o_emt_val  (w_emt_chain[g+1]),
            .o_sec_hit  (w_sec_hit[g]),
            .o_emt_hit  (w_emt_hit[g])
        );
    end

    assign w_sec_any = |w_sec_hit;
    assign w_emt_any = |w_emt_hit;

    always_comb begin
        n_state = r_state;
        case (r_state)
            dsi_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = dsi_pkg::ST_CMP;
                end
            end
            dsi_pkg::ST_CMP: begin
                n_state = dsi_pkg::ST_DONE;
            end
            dsi_pkg::ST_DONE: begin
                if (!r_out_vld || i_ready) begin
                    n_state = dsi_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dsi_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready   = 1'b0;
        w_commit  = 1'b0;
        w_compare = 1'b0;
        case (r_state)
            dsi_pkg::ST_IDLE: begin
                o_ready = 1'b1;
            end
            dsi_pkg::ST_CMP: begin
                w_compare = 1'b1;
            end
            dsi_pkg::ST_DONE: begin
                w_commit = !r_out_vld || i_ready;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_sec_cnt   = r_sec_cnt;
        n_emt_cnt   = r_emt_cnt;
        n_out_value = '0;
        n_out_emit  = 1'b0;
        n_out_match = 1'b0;
        n_out_ovf   = 1'b0;
        n_out_done  = 1'b0;
        w_shift_sec = 1'b0;
        w_shift_emt = 1'b0;
        case (r_req)
            dsi_pkg::REQ_CLEAR: begin
                n_sec_cnt = '0;
                n_emt_cnt = '0;
            end
            dsi_pkg::REQ_LOAD: begin
                if (r_sec_cnt == FULL) begin
                    n_out_ovf = 1'b1;
                end else begin
                    w_shift_sec = w_commit;
                    n_sec_cnt   = r_sec_cnt + 1'b1;
                end
            end
            dsi_pkg::REQ_PROBE: begin
                n_out_done  = r_fin;
                n_out_match = w_sec_any;
                if (w_sec_any && !w_emt_any) begin
                    n_out_emit  = 1'b1;
                    n_out_value = r_key;
                    if (r_emt_cnt != FULL) begin
                        w_shift_emt = w_commit;
                        n_emt_cnt   = r_emt_cnt + 1'b1;
                    end
                end
            end
            default: begin
                n_sec_cnt = r_sec_cnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dsi_pkg::ST_IDLE;
            r_sec_cnt <= '0;
            r_emt_cnt <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_sec_cnt <= n_sec_cnt;
                r_emt_cnt <= n_emt_cnt;
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req <= i_req_type;
            r_key <= i_item_value;
            r_fin <= i_final_probe;
        end
        if (w_commit) begin
            r_out_value <= n_out_value;
            r_out_emit  <= n_out_emit;
            r_out_match <= n_out_match;
            r_out_ovf   <= n_out_ovf;
            r_out_cnt   <= n_emt_cnt;
            r_out_done  <= n_out_done;
        end
    end

    assign w_cnt_ext       = {{dsi_pkg::COUNT_OUT_W{1'b0}}, r_out_cnt};
    assign o_valid         = r_out_vld;
    assign o_out_value     = r_out_value;
    assign o_emitted       = r_out_emit;
    assign o_in_second_set = r_out_match;
    assign o_overflow      = r_out_ovf;
    assign o_emitted_count = w_cnt_ext[dsi_pkg::COUNT_OUT_W-1:0];
    assign o_set_done      = r_out_done;

endmodule
